[rtl/olist_pkg.sv]
package olist_pkg;

	// default list depth
	localparam int unsigned DEPTH_DEF = 16;

	// field widths
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned IDX_W    = 5;
	localparam int unsigned LEN_W    = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_DEL_HEAD = 3'd2,
		CMD_DEL_TAIL = 3'd3,
		CMD_INS_POS  = 3'd4,
		CMD_SEARCH   = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

endpackage

[rtl/olist_mem.sv]
module olist_mem
	import olist_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/ordered_list_engine_unit.sv]
// ordered list engine: one command item in, one result item out on done
// each command walks n stored entries through the list memory (one write port, one registered
// read port), one entry read per cycle (n is 0 .. DEPTH)
// busy stays high from the accept edge until done is raised; it is already low in the cycle that carries done
// results are strobed for one cycle and the receiver cannot stall them
// arst_n clears the list count and the sequencer; list contents are not cleared
module ordered_list_engine_unit
	import olist_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [CMD_W-1:0]           cmd,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [POS_W-1:0]           position,
	output logic                       busy,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [IDX_W-1:0]    found_index,
	output logic [LEN_W-1:0]           length
);

	// index width, count width (holds DEPTH itself), width for position compare
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	// operation held for the walk
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INS,
		OP_DELH,
		OP_DELT,
		OP_SRCH
	} op_t;

	// control state
	state_t             state_q;
	op_t                op_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rem_q;
	logic               hit_q;
	logic               rv_s1;
	logic               done_q;
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]   found_q;
	logic [LEN_W-1:0]   length_q;

	// item payload held during the walk
	logic [VALUE_W-1:0] key_q;
	logic [IW-1:0]      rp_q;
	logic               up_q;
	logic [IW-1:0]      at_q;
	status_t            stat_q;
	logic [IW-1:0]      hidx_q;
	logic [IW-1:0]      ra_s1;
	logic [VALUE_W-1:0] rd_s1;

	// decode of the incoming item
	op_t                d_op;
	status_t            d_stat;
	logic [CW-1:0]      d_rem;
	logic [IW-1:0]      d_rp;
	logic               d_up;
	logic [IW-1:0]      d_at;
	logic [PW-1:0]      pos_w;
	logic [PW-1:0]      cnt_w;
	logic               full;
	logic               empty;

	// walk datapath
	logic               match;
	logic               issue;
	logic               wr_shift;
	logic [IW-1:0]      wa_shift;
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [CW-1:0]      cnt_next;
	logic [IDX_W-1:0]   found_next;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign length      = length_q;

	// command decode: checks, walk length, start pointer and direction
	always_comb begin
		d_op   = OP_NONE;
		d_stat = ST_OK;
		d_rem  = '0;
		d_rp   = '0;
		d_up   = 1'b0;
		d_at   = '0;
		pos_w  = PW'(position);
		cnt_w  = PW'(count_q);
		full   = (count_q == CNT_FULL);
		empty  = (count_q == '0);
		unique case (cmd_t'(cmd))
			CMD_INS_HEAD: begin
				if (full) begin
					d_stat = ST_FULL;
				end else begin
					// shift every entry up by one, walking down from the tail
					d_op  = OP_INS;
					d_at  = '0;
					d_rem = count_q;
					d_rp  = IW'(count_q - CW'(1));
				end
			end
			CMD_INS_TAIL: begin
				if (full) begin
					d_stat = ST_FULL;
				end else begin
					// nothing to move, just drop the item at the end
					d_op = OP_INS;
					d_at = IW'(count_q);
				end
			end
			CMD_INS_POS: begin
				if (pos_w > cnt_w) begin
					d_stat = ST_BADPOS;
				end else if (full) begin
					d_stat = ST_FULL;
				end else begin
					d_op  = OP_INS;
					d_at  = IW'(pos_w);
					d_rem = count_q - CW'(pos_w);
					d_rp  = IW'(count_q - CW'(1));
				end
			end
			CMD_DEL_HEAD: begin
				if (empty) begin
					d_stat = ST_EMPTY;
				end else begin
					// pull entries 1..n-1 down by one
					d_op  = OP_DELH;
					d_rem = count_q - CW'(1);
					d_rp  = IW'(1);
					d_up  = 1'b1;
				end
			end
			CMD_DEL_TAIL: begin
				if (empty) begin
					d_stat = ST_EMPTY;
				end else begin
					d_op = OP_DELT;
				end
			end
			CMD_SEARCH: begin
				d_op  = OP_SRCH;
				d_rem = count_q;
				d_rp  = '0;
				d_up  = 1'b1;
			end
			default: begin
				// unused codes leave the list alone
			end
		endcase
	end

	// one entry read per cycle; the read data is registered and comes back in rd_s1
	assign match    = rv_s1 && (op_q == OP_SRCH) && !hit_q && (rd_s1 == key_q);
	assign issue    = (state_q == S_WALK) && (rem_q != '0) && !match;
	assign wr_shift = (state_q == S_WALK) && rv_s1 && ((op_q == OP_INS) || (op_q == OP_DELH));

	// shared address step: an entry read at a lands at a+1 (insert) or a-1 (delete)
	assign wa_shift = (op_q == OP_INS) ? (ra_s1 + IW'(1)) : (ra_s1 - IW'(1));

	// final write of the new item happens once the shift has drained
	assign mem_we    = wr_shift || ((state_q == S_FIN) && (op_q == OP_INS));
	assign mem_waddr = (state_q == S_FIN) ? at_q : wa_shift;
	assign mem_wdata = (state_q == S_FIN) ? key_q : rd_s1;

	always_comb begin
		unique case (op_q)
			OP_INS:           cnt_next = count_q + CW'(1);
			OP_DELH, OP_DELT: cnt_next = count_q - CW'(1);
			default:          cnt_next = count_q;
		endcase
	end

	// found index: all ones for a miss, zero outside search
	assign found_next = (op_q != OP_SRCH) ? '0 : (hit_q ? IDX_W'(hidx_q) : '1);

	olist_mem #(
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (rp_q),
		.rdata (rd_s1)
	);

	// sequencer and list count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_NONE;
			count_q  <= '0;
			rem_q    <= '0;
			hit_q    <= 1'b0;
			rv_s1    <= 1'b0;
			done_q   <= 1'b0;
			status_q <= '0;
			found_q  <= '0;
			length_q <= '0;
		end else begin
			done_q <= 1'b0;
			rv_s1  <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_WALK;
						op_q    <= d_op;
						rem_q   <= d_rem;
						hit_q   <= 1'b0;
					end
				end
				S_WALK: begin
					if (match) begin
						// first hit ends the search walk
						hit_q <= 1'b1;
						rem_q <= '0;
					end else if (issue) begin
						rem_q <= rem_q - CW'(1);
					end
					// last read data is consumed on this edge
					if (rem_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q  <= S_IDLE;
					count_q  <= cnt_next;
					done_q   <= 1'b1;
					status_q <= stat_q;
					found_q  <= found_next;
					length_q <= LEN_W'(cnt_next);
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and walk pointers
	always_ff @(posedge clk) begin
		ra_s1 <= rp_q;
		if ((state_q == S_IDLE) && start) begin
			key_q  <= value;
			stat_q <= d_stat;
			rp_q   <= d_rp;
			up_q   <= d_up;
			at_q   <= d_at;
		end else if (issue) begin
			rp_q <= up_q ? (rp_q + IW'(1)) : (rp_q - IW'(1));
		end
		if (match) begin
			hidx_q <= ra_s1;
		end
	end

	// a result only ever leaves from the finish state
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIN))
		else $error("result strobe without finish state");

	// list never holds more than DEPTH entries
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("list count above depth");

	// an accepted item makes the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start the sequencer");

	// an error result never carries a search index
	a_err_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> (found_index == '0))
		else $error("search index on an error result");

	// the list length moves by at most one per command
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> ((count_q == $past(count_q))
			|| (count_q == $past(count_q) + CW'(1))
			|| (count_q == $past(count_q) - CW'(1))))
		else $error("list count jumped by more than one");

endmodule
